// ----- hw/rtl/cpd_pkg.sv -----
package cpd_pkg;

    localparam logic [7:0]  START_TAG  = 8'h55;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;
    localparam int          CRC_HDR_BYTES = 4;
    localparam int          CMD_POS    = 4;
    localparam int          PARAM_POS  = 5;

    typedef enum logic [3:0] {
        EV_IGNORED     = 4'd0,
        EV_TAG         = 4'd1,
        EV_HEADER_OK   = 4'd2,
        EV_HEADER_BAD  = 4'd3,
        EV_PAYLOAD     = 4'd4,
        EV_GOOD        = 4'd5,
        EV_CRC_ERROR   = 4'd6,
        EV_SECURED     = 4'd7,
        EV_LINK_RESET  = 4'd8
    } event_t;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_in;
    } item_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  byte_out;
        logic [8:0]  byte_index;
        logic [4:0]  block_count;
        logic        response_wanted;
        logic [7:0]  command;
        logic [7:0]  param;
        logic [31:0] crc_received;
        logic [31:0] crc_computed;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cpd_if.sv -----
interface cpd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_in;

    modport source (output valid, output op, output byte_in, input ready);
    modport sink   (input valid, input op, input byte_in, output ready);
endinterface

interface cpd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [7:0]  byte_out;
    logic [8:0]  byte_index;
    logic [4:0]  block_count;
    logic        response_wanted;
    logic [7:0]  command;
    logic [7:0]  param;
    logic [31:0] crc_received;
    logic [31:0] crc_computed;

    modport source (output valid, output event_res, output byte_out, output byte_index,
                    output block_count, output response_wanted, output command,
                    output param, output crc_received, output crc_computed, input ready);
    modport sink   (input valid, input event_res, input byte_out, input byte_index,
                    input block_count, input response_wanted, input command,
                    input param, input crc_received, input crc_computed, output ready);
endinterface

// ----- hw/rtl/cpd_in_stage.sv -----
module cpd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    cpd_in_if.sink         stream,
    input  logic           advance,
    output logic           item_valid,
    output cpd_pkg::item_t item
);

    logic           vld_reg;
    logic           vld_next;
    cpd_pkg::item_t item_reg;
    logic           accept;

    assign stream.ready = !vld_reg || advance;
    assign accept       = stream.valid && stream.ready;
    assign item_valid   = vld_reg;
    assign item         = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op      <= stream.op;
            item_reg.byte_in <= stream.byte_in;
        end
    end

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && !advance |=> vld_reg && $stable(item_reg))
        else $error("stalled item changed");

endmodule

// ----- hw/rtl/cpd_parser.sv -----
module cpd_parser #(
    parameter int MAX_BLOCKS  = 17,
    parameter int BLOCK_BYTES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  cpd_pkg::item_t   item,
    output cpd_pkg::result_t res
);

    localparam int CNT_W = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [5:0]         blocks_reg;
    logic [5:0]         blocks_next;
    logic [2:0]         flags_reg;
    logic [2:0]         flags_next;
    logic [31:0]        crc_reg;
    logic [31:0]        crc_next;
    logic [31:0]        rx_crc_reg;
    logic [31:0]        rx_crc_next;
    logic [7:0]         cmd_reg;
    logic [7:0]         cmd_next;
    logic [7:0]         param_reg;
    logic [7:0]         param_next;

    logic [7:0]         b;
    logic [5:0]         hdr_blocks;
    logic [31:0]        idx32;
    logic [31:0]        calc;

    assign b          = item.byte_in;
    assign hdr_blocks = b[5:0];
    assign idx32      = 32'(count_reg);
    assign calc       = crc_next ^ cpd_pkg::CRC_XOROUT;

    always_comb
    begin
        phase_next  = phase_reg;
        total_next  = total_reg;
        count_next  = count_reg;
        blocks_next = blocks_reg;
        flags_next  = flags_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        cmd_next    = cmd_reg;
        param_next  = param_reg;
        res         = '0;
        res.event_res = cpd_pkg::EV_IGNORED;

        if (item.op)
        begin
            phase_next    = PH_HUNT;
            total_next    = '0;
            count_next    = '0;
            res.event_res = cpd_pkg::EV_LINK_RESET;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    flags_next          = b[7:5];
                    res.response_wanted = b[7];
                    if (hdr_blocks == 6'd0 || {1'b0, hdr_blocks} > 7'(MAX_BLOCKS))
                    begin
                        phase_next    = PH_HUNT;
                        res.event_res = cpd_pkg::EV_HEADER_BAD;
                    end
                    else
                    begin
                        total_next  = CNT_W'({26'd0, hdr_blocks} * 32'(BLOCK_BYTES));
                        count_next  = '0;
                        blocks_next = hdr_blocks;
                        crc_next    = cpd_pkg::CRC_INIT;
                        rx_crc_next = '0;
                        cmd_next    = '0;
                        param_next  = '0;
                        phase_next  = PH_PAYLOAD;
                        res.event_res   = cpd_pkg::EV_HEADER_OK;
                        res.block_count = hdr_blocks[4:0];
                    end
                end
                PH_PAYLOAD:
                begin
                    if (idx32 < 32'(cpd_pkg::CRC_HDR_BYTES))
                    begin
                        rx_crc_next = {rx_crc_reg[23:0], b};
                    end
                    else
                    begin
                        crc_next = cpd_pkg::crc_byte(crc_reg, b);
                        if (idx32 == 32'(cpd_pkg::CMD_POS))
                        begin
                            cmd_next = b;
                        end
                        else if (idx32 == 32'(cpd_pkg::PARAM_POS))
                        begin
                            param_next = b;
                        end
                    end
                    count_next          = count_reg + 1'b1;
                    res.byte_out        = b;
                    res.byte_index      = idx32[8:0];
                    res.block_count     = blocks_reg[4:0];
                    res.response_wanted = flags_reg[2];
                    if (count_next >= total_reg)
                    begin
                        if (calc != rx_crc_next)
                        begin
                            res.event_res = cpd_pkg::EV_CRC_ERROR;
                        end
                        else if (flags_reg[1:0] != 2'b00)
                        begin
                            res.event_res = cpd_pkg::EV_SECURED;
                        end
                        else
                        begin
                            res.event_res = cpd_pkg::EV_GOOD;
                        end
                        res.command      = cmd_next;
                        res.param        = param_next;
                        res.crc_received = rx_crc_next;
                        res.crc_computed = calc;
                        phase_next       = PH_HUNT;
                    end
                    else
                    begin
                        res.event_res = cpd_pkg::EV_PAYLOAD;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (b == cpd_pkg::START_TAG)
                    begin
                        phase_next    = PH_HEADER;
                        res.event_res = cpd_pkg::EV_TAG;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            total_reg <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            total_reg <= total_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            blocks_reg <= blocks_next;
            flags_reg  <= flags_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
            cmd_reg    <= cmd_next;
            param_reg  <= param_next;
        end
    end

    a_verdict_ends: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res.event_res == cpd_pkg::EV_GOOD || res.event_res == cpd_pkg::EV_CRC_ERROR
                 || res.event_res == cpd_pkg::EV_SECURED)
        |=> phase_reg == PH_HUNT)
        else $error("phase did not return to hunting after verdict");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> count_reg < total_reg)
        else $error("payload count reached total without verdict");

    a_link_reset: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op |=> phase_reg == PH_HUNT && count_reg == '0 && total_reg == '0)
        else $error("link reset did not clear parser");

endmodule

// ----- hw/rtl/cpd_out_stage.sv -----
module cpd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cpd_pkg::result_t res,
    output logic             free,
    cpd_out_if.source        result
);

    logic             vld_reg;
    logic             vld_next;
    cpd_pkg::result_t res_reg;

    assign free = !vld_reg || result.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid           = vld_reg;
    assign result.event_res       = res_reg.event_res;
    assign result.byte_out        = res_reg.byte_out;
    assign result.byte_index      = res_reg.byte_index;
    assign result.block_count     = res_reg.block_count;
    assign result.response_wanted = res_reg.response_wanted;
    assign result.command         = res_reg.command;
    assign result.param           = res_reg.param;
    assign result.crc_received    = res_reg.crc_received;
    assign result.crc_computed    = res_reg.crc_computed;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !vld_reg || result.ready)
        else $error("pending item overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> vld_reg)
        else $error("loaded item not presented");

endmodule

// ----- hw/rtl/crc32_packet_deframer_unit.sv -----
// Channel   Dir   Handshake      Payload
// stream    in    valid/ready    op, byte_in
// result    out   valid/ready    event_res, byte_out, byte_index, block_count,
//                                response_wanted, command, param,
//                                crc_received, crc_computed
//
// One item per cycle unless the result stalls; an accepted item sits in the input register,
// then passes the parser state and one-byte CRC-32 update into the result register.
// rst_n clears both stage valids and returns the parser to tag hunting.
// A stalled result holds; the input register takes an item while it is empty, or while the
// result register is free or drains in the same cycle.
module crc32_packet_deframer_unit #(
    parameter int MAX_BLOCKS  = 17,
    parameter int BLOCK_BYTES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    cpd_in_if.sink    stream,
    cpd_out_if.source result
);

    logic             item_valid;
    cpd_pkg::item_t   item;
    cpd_pkg::result_t res;
    logic             out_free;
    logic             advance;

    assign advance = item_valid && out_free;

    cpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cpd_parser #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item),
        .res   (res)
    );

    cpd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .res    (res),
        .free   (out_free),
        .result (result)
    );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int MAX_BLOCKS  = 17;
    localparam int BLOCK_BYTES = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_LATENCY = 2;
    localparam int PRINT_LIMIT  = 30;

    localparam logic [7:0] FLAG_RESPONSE  = 8'h80;
    localparam logic [7:0] FLAG_ENCRYPTED = 8'h40;

    localparam int CORRUPT_NONE = 0;
    localparam int CORRUPT_CRC  = 1;
    localparam int CORRUPT_BODY = 2;
    localparam int NO_CUT       = -1;

    localparam logic OP_BYTE       = 1'b0;
    localparam logic OP_LINK_RESET = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    cpd_in_if  stream_ch ();
    cpd_out_if result_ch ();

    crc32_packet_deframer_unit #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    always #10 clk = ~clk;

    // parser state mirror
    parse_phase_t phase_m;
    logic [8:0]   total_m;
    logic [8:0]   count_m;
    logic [2:0]   flags_m;
    logic [31:0]  crc_acc_m;
    logic [31:0]  crc_rx_m;
    logic [7:0]   cmd_m;
    logic [7:0]   param_m;

    cpd_pkg::result_t pending_events[$];
    cpd_pkg::result_t observed;
    cpd_pkg::result_t wanted;

    int err_count    = 0;
    int result_seen  = 0;
    int frame_items  = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit send_gaps    = 1'b1;
    int hold_req     = 0;
    int hold_left    = 0;
    int rx_mode      = 0;
    int rx_tick      = 0;

    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] acc;
        logic        fb;
        acc = c;
        for (int k = 0; k < 8; k++)
        begin
            fb  = acc[0] ^ d[k];
            acc = {1'b0, acc[31:1]} ^ (fb ? cpd_pkg::CRC_POLY : 32'd0);
        end
        return acc;
    endfunction

    function automatic cpd_pkg::result_t deframe_step(input logic op, input logic [7:0] b);
        cpd_pkg::result_t r;
        logic [5:0] blocks;
        logic [8:0] idx;
        logic [31:0] calc;
        r = '0;
        if (op == OP_LINK_RESET)
        begin
            phase_m = PH_HUNT;
            total_m = '0;
            count_m = '0;
            r.event_res = cpd_pkg::EV_LINK_RESET;
        end
        else
        begin
            case (phase_m)
                PH_HEADER:
                begin
                    blocks  = b[5:0];
                    flags_m = b[7:5];
                    r.response_wanted = flags_m[2];
                    if (blocks < 1 || blocks > MAX_BLOCKS)
                    begin
                        phase_m = PH_HUNT;
                        r.event_res = cpd_pkg::EV_HEADER_BAD;
                    end
                    else
                    begin
                        total_m   = 9'(blocks * BLOCK_BYTES);
                        count_m   = '0;
                        crc_acc_m = cpd_pkg::CRC_INIT;
                        crc_rx_m  = '0;
                        cmd_m     = '0;
                        param_m   = '0;
                        phase_m   = PH_PAYLOAD;
                        r.event_res   = cpd_pkg::EV_HEADER_OK;
                        r.block_count = 5'(blocks);
                    end
                end
                PH_PAYLOAD:
                begin
                    idx = count_m;
                    if (idx < cpd_pkg::CRC_HDR_BYTES)
                        crc_rx_m = {crc_rx_m[23:0], b};
                    else
                    begin
                        crc_acc_m = crc32_update(crc_acc_m, b);
                        if (idx == cpd_pkg::CMD_POS)
                            cmd_m = b;
                        else if (idx == cpd_pkg::PARAM_POS)
                            param_m = b;
                    end
                    count_m = idx + 9'd1;
                    r.byte_out        = b;
                    r.byte_index      = idx;
                    r.block_count     = 5'(total_m / BLOCK_BYTES);
                    r.response_wanted = flags_m[2];
                    if (count_m >= total_m)
                    begin
                        calc = crc_acc_m ^ cpd_pkg::CRC_XOROUT;
                        if (calc != crc_rx_m)
                            r.event_res = cpd_pkg::EV_CRC_ERROR;
                        else if (flags_m[1:0] != 2'b00)
                            r.event_res = cpd_pkg::EV_SECURED;
                        else
                            r.event_res = cpd_pkg::EV_GOOD;
                        r.command      = cmd_m;
                        r.param        = param_m;
                        r.crc_received = crc_rx_m;
                        r.crc_computed = calc;
                        phase_m = PH_HUNT;
                    end
                    else
                        r.event_res = cpd_pkg::EV_PAYLOAD;
                end
                default:
                begin
                    phase_m = PH_HUNT;
                    if (b == cpd_pkg::START_TAG)
                    begin
                        phase_m = PH_HEADER;
                        r.event_res = cpd_pkg::EV_TAG;
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h",
                     result_seen, what, got, want);
    endtask

    task automatic compare_result(input cpd_pkg::result_t got, input cpd_pkg::result_t want);
        if (got.event_res !== want.event_res)
            report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
        if (got.byte_out !== want.byte_out)
            report_mismatch("byte_out", 32'(got.byte_out), 32'(want.byte_out));
        if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", 32'(got.byte_index), 32'(want.byte_index));
        if (got.block_count !== want.block_count)
            report_mismatch("block_count", 32'(got.block_count), 32'(want.block_count));
        if (got.response_wanted !== want.response_wanted)
            report_mismatch("response_wanted", 32'(got.response_wanted),
                            32'(want.response_wanted));
        if (got.command !== want.command)
            report_mismatch("command", 32'(got.command), 32'(want.command));
        if (got.param !== want.param)
            report_mismatch("param", 32'(got.param), 32'(want.param));
        if (got.crc_received !== want.crc_received)
            report_mismatch("crc_received", got.crc_received, want.crc_received);
        if (got.crc_computed !== want.crc_computed)
            report_mismatch("crc_computed", got.crc_computed, want.crc_computed);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            observed.event_res       = result_ch.event_res;
            observed.byte_out        = result_ch.byte_out;
            observed.byte_index      = result_ch.byte_index;
            observed.block_count     = result_ch.block_count;
            observed.response_wanted = result_ch.response_wanted;
            observed.command         = result_ch.command;
            observed.param           = result_ch.param;
            observed.crc_received    = result_ch.crc_received;
            observed.crc_computed    = result_ch.crc_computed;
            if (pending_events.size() == 0)
                report_mismatch("unexpected result, event_res", 32'(observed.event_res),
                                32'd0);
            else
            begin
                wanted = pending_events.pop_front();
                compare_result(observed, wanted);
            end
            result_seen++;
        end
    end

    // receiver stall pattern, with long hold-offs on request
    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_tick % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            result_ch.ready = 1'b0;
            hold_left--;
        end
        else
        begin
            case (rx_mode)
                0: result_ch.ready = 1'b1;
                1: result_ch.ready = ($urandom_range(0, 3) != 0);
                2: result_ch.ready = (rx_tick % 3 != 0);
                default: result_ch.ready = 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic op, input logic [7:0] b);
        cpd_pkg::result_t r;
        if (send_gaps && burst_left == 0)
        begin
            stream_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        stream_ch.valid   = 1'b1;
        stream_ch.op      = op;
        stream_ch.byte_in = b;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        r = deframe_step(op, b);
        pending_events.push_back(r);
        if (r.event_res != cpd_pkg::EV_IGNORED)
            frame_items++;
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
    endtask

    task automatic wait_all_done();
        stream_ch.valid = 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input int corrupt, input int cut_at);
        logic [7:0]  body[$];
        logic [31:0] c;
        int          total;
        int          k;
        total = hdr[5:0] * BLOCK_BYTES;
        body = {};
        for (int i = 0; i < total; i++)
            body.push_back(8'($urandom_range(0, 255)));
        c = cpd_pkg::CRC_INIT;
        for (int i = cpd_pkg::CRC_HDR_BYTES; i < total; i++)
            c = crc32_update(c, body[i]);
        c = c ^ cpd_pkg::CRC_XOROUT;
        body[0] = c[31:24];
        body[1] = c[23:16];
        body[2] = c[15:8];
        body[3] = c[7:0];
        if (corrupt == CORRUPT_CRC)
        begin
            k = $urandom_range(0, cpd_pkg::CRC_HDR_BYTES - 1);
            body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (corrupt == CORRUPT_BODY)
        begin
            k = $urandom_range(cpd_pkg::CRC_HDR_BYTES, total - 1);
            body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_BYTE, hdr);
        for (int i = 0; i < total; i++)
        begin
            if (i == cut_at)
            begin
                send_item(OP_LINK_RESET, 8'($urandom_range(0, 255)));
                return;
            end
            send_item(OP_BYTE, body[i]);
        end
    endtask

    task automatic test_header_cases();
        send_item(OP_LINK_RESET, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_BYTE, FLAG_RESPONSE | 8'd18);
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_LINK_RESET, 8'hFF);
        send_item(OP_BYTE, cpd_pkg::START_TAG);
        send_item(OP_BYTE, 8'd17);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_LINK_RESET, 8'h55);
        send_item(OP_BYTE, 8'h01);
        wait_all_done();
    endtask

    task automatic test_verdicts();
        send_packet(FLAG_RESPONSE | 8'd1, CORRUPT_NONE, NO_CUT);
        send_packet(8'd1, CORRUPT_CRC, NO_CUT);
        send_packet(FLAG_ENCRYPTED | 8'd1, CORRUPT_NONE, NO_CUT);
        send_packet(FLAG_RESPONSE | FLAG_ENCRYPTED | 8'd1, CORRUPT_BODY, NO_CUT);
        wait_all_done();
    endtask

    task automatic test_backpressure();
        send_gaps = 1'b0;
        hold_req  = 200;
        send_packet(FLAG_RESPONSE | 8'd2, CORRUPT_NONE, NO_CUT);
        send_gaps = 1'b1;
        wait_all_done();
    endtask

    task automatic test_random_traffic();
        int         sel;
        int         total;
        int         cut;
        int         corrupt;
        logic [5:0] blocks;
        logic [7:0] hdr;
        send_packet({2'($urandom_range(0, 3)), 6'(MAX_BLOCKS)}, CORRUPT_NONE, NO_CUT);
        while (frame_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            send_gaps = ($urandom_range(0, 3) != 0);
            if (sel < 70)
            begin
                blocks = ($urandom_range(0, 19) == 0) ? 6'(MAX_BLOCKS) : 6'($urandom_range(1, 3));
                hdr = {2'($urandom_range(0, 3)), blocks};
                total = blocks * BLOCK_BYTES;
                corrupt = ($urandom_range(0, 9) < 7) ? CORRUPT_NONE : $urandom_range(1, 2);
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : NO_CUT;
                send_packet(hdr, corrupt, cut);
            end
            else if (sel < 80)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255)));
            end
            else if (sel < 90)
            begin
                blocks = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(MAX_BLOCKS + 1, 63));
                send_item(OP_BYTE, cpd_pkg::START_TAG);
                send_item(OP_BYTE, {2'($urandom_range(0, 3)), blocks});
            end
            else if (sel < 95)
            begin
                send_item(OP_BYTE, cpd_pkg::START_TAG);
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else
                wait_all_done();
        end
        wait_all_done();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        stream_ch.valid   = 1'b0;
        stream_ch.op      = 1'b0;
        stream_ch.byte_in = 8'h00;
        result_ch.ready   = 1'b0;
        phase_m   = PH_HUNT;
        total_m   = '0;
        count_m   = '0;
        flags_m   = '0;
        crc_acc_m = cpd_pkg::CRC_INIT;
        crc_rx_m  = '0;
        cmd_m     = '0;
        param_m   = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_header_cases();
        test_verdicts();
        test_backpressure();
        test_random_traffic();

        if (pending_events.size() != 0)
            report_mismatch("results never arrived, count", pending_events.size(), 32'd0);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- crc32_packet_deframer_unit.f -----
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_if.sv
hw/rtl/cpd_in_stage.sv
hw/rtl/cpd_parser.sv
hw/rtl/cpd_out_stage.sv
hw/rtl/crc32_packet_deframer_unit.sv
sim/tb.sv
